// ----- sv/mas_pkg.sv -----
// Shared types and codes for the matrix add / subtract / multiply block.
// No dependencies; imported by the sequencer, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

    // input operation codes
    localparam logic [1:0] OP_WR_A    = 2'd0;
    localparam logic [1:0] OP_WR_B    = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // mode register codes; the remaining code acts as product
    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_SUB  = 2'd1;
    localparam logic [1:0] MODE_PROD = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ROWS_A = 2'd1;
    localparam logic [1:0] REG_COLS_A = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    localparam int DIM_W = 4;   // width of a dimension register and loop counter
    localparam int IDX_W = 3;   // width of a row / column field
    localparam int OUT_W = 32;  // width of the value ports

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } t_state;

    // per-read control that travels down the datapath next to the memory data
    typedef struct packed {
        logic             valid;
        logic             first;  // first term of a dot product
        logic             lastk;  // last term: element is finished
        logic             zero;   // empty inner dimension, term is zero
        logic             prod;
        logic             sub;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;   // final element of the result matrix
    } t_tag;

endpackage

`default_nettype wire

// ----- sv/mas_ram.sv -----
// Simple dual-port element store: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mas_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/mas_seq.sv -----
// Sequencer: post-reset clearing sweep, element writes, and the row / column /
// inner-index walk that issues store reads for a compute. Uses mas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mas_seq #(
    parameter int MAX_DIM = 8,
    parameter int EW      = 32,
    parameter int AW      = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    input  wire logic [1:0]                i_operation,
    input  wire logic [mas_pkg::IDX_W-1:0] i_row_index,
    input  wire logic [mas_pkg::IDX_W-1:0] i_col_index,
    input  wire logic [EW-1:0]             i_value,
    input  wire logic [1:0]                i_mode,
    input  wire logic [mas_pkg::DIM_W-1:0] i_rows_a,
    input  wire logic [mas_pkg::DIM_W-1:0] i_cols_a,
    input  wire logic [mas_pkg::DIM_W-1:0] i_cols_b,
    output logic                           busy,
    output logic                           o_a_we,
    output logic                           o_b_we,
    output logic      [AW-1:0]             o_waddr,
    output logic      [EW-1:0]             o_wdata,
    output logic      [AW-1:0]             o_a_raddr,
    output logic      [AW-1:0]             o_b_raddr,
    output mas_pkg::t_tag                  o_tag
);

    import mas_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'((MAX_DIM > 15) ? 15 : MAX_DIM);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [DIM_W-1:0] r_r, n_r, r_c, n_c, r_k, n_k;

    logic [DIM_W-1:0] w_ra, w_ca, w_cb, w_rc, w_inner, w_kmax;
    logic             w_prod, w_sub, w_zero, w_busy, w_accept;
    logic             w_lastk, w_lastc, w_lastr, w_start_run;
    logic             w_a_in, w_b_in;
    logic [DIM_W-1:0] w_row, w_col;

    // dimensions above the store size act as the store size
    assign w_ra = (i_rows_a > DIM_CAP) ? DIM_CAP : i_rows_a;
    assign w_ca = (i_cols_a > DIM_CAP) ? DIM_CAP : i_cols_a;
    assign w_cb = (i_cols_b > DIM_CAP) ? DIM_CAP : i_cols_b;

    assign w_sub   = (i_mode == MODE_SUB);
    assign w_prod  = !(i_mode == MODE_ADD || i_mode == MODE_SUB);
    assign w_rc    = w_prod ? w_cb : w_ca;
    assign w_inner = w_prod ? w_ca : DIM_W'(1);
    // empty inner dimension: one pass with a zero term per element
    assign w_zero  = w_prod && (w_ca == '0);
    assign w_kmax  = w_zero ? '0 : w_inner - DIM_W'(1);

    assign w_lastk = (r_k == w_kmax);
    assign w_lastc = (r_c == w_rc - DIM_W'(1));
    assign w_lastr = (r_r == w_ra - DIM_W'(1));

    assign w_busy      = (r_state != ST_IDLE);
    assign w_accept    = start && !w_busy;
    assign w_start_run = w_accept && (i_operation == OP_COMPUTE) &&
                         (w_ra != '0) && (w_rc != '0);

    assign w_row  = {1'b0, i_row_index};
    assign w_col  = {1'b0, i_col_index};
    assign w_a_in = (w_row < w_ra) && (w_col < w_ca);
    assign w_b_in = w_prod ? ((w_row < w_ca) && (w_col < w_cb))
                           : ((w_row < w_ra) && (w_col < w_ca));

    // next state
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_r     = r_r;
        n_c     = r_c;
        n_k     = r_k;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_start_run) begin
                    n_state = ST_RUN;
                    n_r     = '0;
                    n_c     = '0;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                if (!w_lastk) begin
                    n_k = r_k + DIM_W'(1);
                end else begin
                    n_k = '0;
                    if (!w_lastc) begin
                        n_c = r_c + DIM_W'(1);
                    end else begin
                        n_c = '0;
                        if (w_lastr) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_r = r_r + DIM_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy        = w_busy;
        o_a_we      = 1'b0;
        o_b_we      = 1'b0;
        o_waddr     = AW'(int'(i_row_index) * MAX_DIM + int'(i_col_index));
        o_wdata     = i_value;
        o_tag       = '0;
        o_tag.first = (r_k == '0);
        o_tag.lastk = w_lastk;
        o_tag.zero  = w_zero;
        o_tag.prod  = w_prod;
        o_tag.sub   = w_sub;
        o_tag.row   = r_r[IDX_W-1:0];
        o_tag.col   = r_c[IDX_W-1:0];
        o_tag.last  = w_lastk && w_lastc && w_lastr;
        if (w_prod) begin
            o_a_raddr = AW'(int'(r_r) * MAX_DIM + int'(r_k));
            o_b_raddr = AW'(int'(r_k) * MAX_DIM + int'(r_c));
        end else begin
            o_a_raddr = AW'(int'(r_r) * MAX_DIM + int'(r_c));
            o_b_raddr = o_a_raddr;
        end
        case (r_state)
            ST_CLEAR: begin
                o_a_we  = 1'b1;
                o_b_we  = 1'b1;
                o_waddr = r_clr;
                o_wdata = '0;
            end
            ST_IDLE: begin
                o_a_we = w_accept && (i_operation == OP_WR_A) && w_a_in;
                o_b_we = w_accept && (i_operation == OP_WR_B) && w_b_in;
            end
            ST_RUN: begin
                o_tag.valid = 1'b1;
            end
            default: begin
                o_tag.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_r     <= '0;
            r_c     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_r     <= n_r;
            r_c     <= n_c;
            r_k     <= n_k;
        end
    end

`ifndef SYNTH
    // stores are only read-walked with no writes in flight
    a_no_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (!o_a_we && !o_b_we))
        else $error("store write during compute walk");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_CLEAR && r_clr == '0))
        else $error("reset did not restart clearing sweep");

    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start_run |=> (r_state == ST_RUN && r_r == '0 && r_c == '0 && r_k == '0))
        else $error("accepted compute did not start walk");
`endif

endmodule

`default_nettype wire

// ----- sv/mas_dp.sv -----
// Datapath: term (product or sum/difference), accumulate, round, saturate,
// and the registered result beat. Uses mas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mas_dp #(
    parameter int EW        = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mas_pkg::t_tag             i_tag,
    input  wire logic [EW-1:0]             i_a_q,
    input  wire logic [EW-1:0]             i_b_q,
    output logic                           o_valid,
    output logic [mas_pkg::IDX_W-1:0]      o_out_row,
    output logic [mas_pkg::IDX_W-1:0]      o_out_col,
    output logic [mas_pkg::OUT_W-1:0]      o_out_value,
    output logic                           o_overflow,
    output logic                           o_last
);

    import mas_pkg::*;

    localparam int PROD_W = 2 * EW;
    // exact sum of up to 15 products plus the rounding carry
    localparam int ACC_W  = PROD_W + 5;

    localparam logic signed [ACC_W-1:0] VMAX =
        {{(ACC_W - EW + 1){1'b0}}, {(EW - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] VMIN = ~VMAX;
    localparam logic signed [EW-1:0]    EMAX = VMAX[EW-1:0];
    localparam logic signed [EW-1:0]    EMIN = VMIN[EW-1:0];
    localparam logic signed [ACC_W-1:0] HALF = (FRAC_BITS > 0) ?
        (ACC_W'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;

    t_tag r_s1, r_s2, r_s3, r_s4;
    t_tag w_s3;

    logic signed [EW-1:0]     w_a, w_b;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [ACC_W-1:0]  w_term, w_acc, w_shift;
    logic signed [EW-1:0]     w_sat;
    logic                     w_ovf;

    logic signed [ACC_W-1:0]  r_term, r_acc, r_rnd;

    assign w_a   = i_a_q;
    assign w_b   = i_b_q;
    assign w_mul = w_a * w_b;

    always_comb begin
        if (r_s1.zero) begin
            w_term = '0;
        end else if (r_s1.prod) begin
            w_term = ACC_W'(w_mul);
        end else if (r_s1.sub) begin
            w_term = ACC_W'(w_a) - ACC_W'(w_b);
        end else begin
            w_term = ACC_W'(w_a) + ACC_W'(w_b);
        end
    end

    assign w_acc = r_s2.first ? r_term : r_acc + r_term;

    // only a finished element moves on to rounding
    always_comb begin
        w_s3       = r_s2;
        w_s3.valid = r_s2.valid && r_s2.lastk;
    end

    // drop fraction bits only for products; round half up already added
    assign w_shift = r_s4.prod ? (r_rnd >>> FRAC_BITS) : r_rnd;

    always_comb begin
        w_ovf = 1'b1;
        if (w_shift > VMAX) begin
            w_sat = EMAX;
        end else if (w_shift < VMIN) begin
            w_sat = EMIN;
        end else begin
            w_sat = w_shift[EW-1:0];
            w_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_s1       <= i_tag;
            r_s2       <= r_s1;
            r_s3       <= w_s3;
            r_s4       <= r_s3;
            o_valid    <= r_s4.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= w_term;
        if (r_s2.valid) begin
            r_acc <= w_acc;
        end
        r_rnd       <= r_s3.prod ? r_acc + HALF : r_acc;
        o_out_row   <= r_s4.row;
        o_out_col   <= r_s4.col;
        o_out_value <= OUT_W'(w_sat);
        o_overflow  <= w_ovf;
        o_last      <= r_s4.last;
    end

`ifndef SYNTH
    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_out_value == OUT_W'(EMAX) || o_out_value == OUT_W'(EMIN)))
        else $error("overflow flagged on unsaturated value");

    a_emit_on_lastk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3.valid |-> $past(r_s2.valid && r_s2.lastk))
        else $error("element emitted before its last term");

    a_last_in_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3.valid && r_s3.last) |=> (r_s4.valid && r_s4.last))
        else $error("last marker lost in rounding stage");
`endif

endmodule

`default_nettype wire

// ----- sv/matrix_add_sub_multiply.sv -----
// Compute: the walk issues one store read pair per inner term, with n terms per
// result element, n = 1 for add/subtract and max(1, cols_a) for the product. The
// terms pass the registered store read, term and accumulate registers, and each
// finished element then the rounding and output registers. busy stays high for the whole walk.
// Reset: synchronous; a clearing sweep zeroes both stores with busy high.
// Result beats cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module matrix_add_sub_multiply #(
    parameter int MAX_DIM     = 8,
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_operation,
    input  wire logic [mas_pkg::IDX_W-1:0] i_row_index,
    input  wire logic [mas_pkg::IDX_W-1:0] i_col_index,
    input  wire logic [mas_pkg::OUT_W-1:0] i_elem_value,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [mas_pkg::DIM_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic [mas_pkg::IDX_W-1:0]      o_out_row,
    output logic [mas_pkg::IDX_W-1:0]      o_out_col,
    output logic [mas_pkg::OUT_W-1:0]      o_out_value,
    output logic                           o_overflow,
    output logic                           o_last
);

    import mas_pkg::*;

    localparam int EW    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [1:0]       r_mode;
    logic [DIM_W-1:0] r_rows_a, r_cols_a, r_cols_b;

    logic          w_a_we, w_b_we;
    logic [AW-1:0] w_waddr, w_a_raddr, w_b_raddr;
    logic [EW-1:0] w_wdata, w_a_q, w_b_q;
    t_tag          w_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PROD;
            r_rows_a <= DIM_W'(8);
            r_cols_a <= DIM_W'(8);
            r_cols_b <= DIM_W'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_mode   <= i_cfg_data[1:0];
                REG_ROWS_A: r_rows_a <= i_cfg_data;
                REG_COLS_A: r_cols_a <= i_cfg_data;
                REG_COLS_B: r_cols_b <= i_cfg_data;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    mas_seq #(
        .MAX_DIM (MAX_DIM),
        .EW      (EW),
        .AW      (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_value     (i_elem_value[EW-1:0]),
        .i_mode      (r_mode),
        .i_rows_a    (r_rows_a),
        .i_cols_a    (r_cols_a),
        .i_cols_b    (r_cols_b),
        .busy        (busy),
        .o_a_we      (w_a_we),
        .o_b_we      (w_b_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_a_raddr   (w_a_raddr),
        .o_b_raddr   (w_b_raddr),
        .o_tag       (w_tag)
    );

    mas_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (EW)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_q)
    );

    mas_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (EW)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_q)
    );

    mas_dp #(
        .EW        (EW),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (w_tag),
        .i_a_q       (w_a_q),
        .i_b_q       (w_b_q),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
